/* rtl/lae_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the linear ADSR envelope.
// No dependencies.
package lae_pkg;

  localparam int unsigned CoarseTicksDef = 15;
  localparam int unsigned TimeWidthDef   = 16;
  localparam int unsigned TickPortW      = 16;
  localparam int unsigned CfgDataW       = 16;
  localparam int unsigned LevelW         = 15;
  localparam int unsigned SlopeW         = 11;
  localparam int unsigned VolW           = 32;
  localparam int unsigned SlopeShift     = 21;
  localparam int unsigned FracW          = 16;
  localparam logic [VolW-1:0] FullScale  = 32'h7fff0000;

  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_KEY_ON     = 3'd1,
    REQ_OFF_DEF    = 3'd2,
    REQ_OFF_GIVEN  = 3'd3,
    REQ_COARSE     = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    CFG_ATTACK   = 2'd0,
    CFG_DECAY    = 2'd1,
    CFG_SUSTAIN  = 2'd2,
    CFG_RELEASE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_ATTACK  = 2'd0,
    PH_DECAY   = 2'd1,
    PH_HOLD    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SEG_ATTACK  = 2'd0,
    SEG_DECAY   = 2'd1,
    SEG_SUSTAIN = 2'd2,
    SEG_END     = 2'd3
  } seg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/lae_if.sv */
`timescale 1ns / 1ps
// Valid/ready channels for envelope requests and results.
// Depends on lae_pkg for field widths.
interface lae_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           req_type;
  logic [lae_pkg::TickPortW-1:0]        release_ticks;

  modport source (output valid, output req_type, output release_ticks, input ready);
  modport sink (input valid, input req_type, input release_ticks, output ready);
endinterface

interface lae_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [lae_pkg::LevelW-1:0]           level;
  logic signed [lae_pkg::SlopeW-1:0]    slope;
  logic                                 done_res;

  modport source (output valid, output level, output slope, output done_res, input ready);
  modport sink (input valid, input level, input slope, input done_res, output ready);
endinterface

/* rtl/lae_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// Depends on lae_pkg for the status struct.
module lae_div #(
  parameter int unsigned DvsW = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lae_pkg::VolW-1:0]  dividend,
  input  logic [DvsW-1:0]           divisor,
  output lae_pkg::div_stat_t        stat,
  output logic [lae_pkg::VolW-1:0]  quotient
);
  import lae_pkg::*;

  localparam int unsigned CntW = $clog2(VolW);

  logic [VolW-1:0] q_r;
  logic [DvsW:0]   rem_r;
  logic [DvsW-1:0] dvs_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [DvsW:0]   rem_sh;
  logic            ge;
  logic [DvsW:0]   rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[DvsW-1:0], q_r[VolW-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(VolW - 1);
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= {q_r[VolW-2:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

/* rtl/linear_adsr_envelope.sv */
`timescale 1ns / 1ps
// Linear ADSR envelope for one voice: the sequencer, the envelope state and the
// result register. Depends on lae_pkg, lae_if.sv and lae_div.
//
// Requests arrive on in_req (tick, key-on, key-off with the default or a given
// time, coarse tick) and each one yields exactly one result on out_res: the
// integer level, the slope and a done flag. The user must write registers through
// cfg_we, cfg_index and cfg_wdata only while no request is in flight; the block
// does not enforce it. One request is worked at a time; in_req.ready is high
// only when idle. A request that sets up an attack, decay or release ramp runs
// the shared divider and waits for it, as does a tick whose count expires into a
// new ramp. A coarse tick steps one tick per cycle, up to COARSE_TICKS of them,
// except while it waits for the divider on a ramp set up on the way, and stops
// early when the envelope finishes or holds at sustain. The result sits in an
// output register; a stalled receiver delays only the following request, which
// waits before its result is loaded. After reset the envelope is finished at
// level zero and all configuration registers are 0.
module linear_adsr_envelope #(
  parameter int unsigned COARSE_TICKS = lae_pkg::CoarseTicksDef,
  parameter int unsigned TIME_WIDTH   = lae_pkg::TimeWidthDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lae_req_if.sink                          in_req,
  lae_res_if.source                        out_res,
  input  logic                             cfg_we,
  input  lae_pkg::cfg_idx_t                cfg_index,
  input  logic [lae_pkg::CfgDataW-1:0]     cfg_wdata
);
  import lae_pkg::*;

  localparam int unsigned CntW = (TIME_WIDTH < TickPortW) ? TIME_WIDTH : TickPortW;
  localparam int unsigned RemW = $clog2(COARSE_TICKS + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_TICK, S_FIN} state_t;

  logic [TickPortW-1:0] attack_r;
  logic [TickPortW-1:0] decay_r;
  logic [LevelW-1:0]    sustain_r;
  logic [TickPortW-1:0] reldef_r;

  state_t            state_r;
  phase_t            phase_r;
  logic [VolW-1:0]   volume_r;
  logic [VolW-1:0]   delta_r;
  logic [CntW-1:0]   left_r;
  logic              finished_r;
  logic [RemW-1:0]   rem_r;
  logic              neg_r;
  logic              resume_r;
  logic [LevelW-1:0] res_level_r;
  logic [SlopeW-1:0] res_slope_r;
  logic              res_done_r;
  logic              out_valid_r;
  logic [LevelW-1:0] out_level_r;
  logic [SlopeW-1:0] out_slope_r;
  logic              out_done_r;

  logic              accept;
  logic [CntW-1:0]   attack_n;
  logic [CntW-1:0]   decay_n;
  logic [CntW-1:0]   rel_n;
  logic              is_release;
  logic              expire;
  logic [RemW-1:0]   rem_dec;
  seg_t              seg_sel;
  phase_t            su_phase;
  logic [VolW-1:0]   su_vol;
  logic [CntW-1:0]   su_left;
  logic              su_need_div;
  logic              su_neg;
  logic              su_end;
  logic [VolW-1:0]   su_dvd;
  logic [CntW-1:0]   su_dvs;
  logic              div_start;
  logic [VolW-1:0]   div_dvd;
  logic [CntW-1:0]   div_dvs;
  logic [VolW-1:0]   div_q;
  div_stat_t         div_stat;
  logic [VolW-1:0]   slope_mag;
  logic [SlopeW-1:0] slope_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= '0;
      decay_r   <= '0;
      sustain_r <= '0;
      reldef_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ATTACK:  attack_r  <= cfg_wdata;
        CFG_DECAY:   decay_r   <= cfg_wdata;
        CFG_SUSTAIN: sustain_r <= cfg_wdata[LevelW-1:0];
        CFG_RELEASE: reldef_r  <= cfg_wdata;
      endcase
    end
  end

  always_comb begin
    accept     = (state_r == S_IDLE) && in_req.valid;
    attack_n   = attack_r[CntW-1:0];
    decay_n    = decay_r[CntW-1:0];
    rel_n      = (in_req.req_type == REQ_OFF_GIVEN) ? in_req.release_ticks[CntW-1:0]
                                                    : reldef_r[CntW-1:0];
    is_release = (in_req.req_type == REQ_OFF_DEF) || (in_req.req_type == REQ_OFF_GIVEN);
    expire     = !finished_r && (phase_r != PH_HOLD) && (left_r <= CntW'(1));
    rem_dec    = rem_r - RemW'(1);
  end

  always_comb begin
    if (state_r == S_IDLE) begin
      seg_sel = SEG_ATTACK;
    end else begin
      unique case (phase_r)
        PH_ATTACK: seg_sel = SEG_DECAY;
        PH_DECAY:  seg_sel = SEG_SUSTAIN;
        default:   seg_sel = SEG_END;
      endcase
    end
  end

  // The cascade from a segment onward, skipping an attack or decay of zero length and a sustain of level zero.
  always_comb begin
    su_phase    = PH_RELEASE;
    su_vol      = '0;
    su_left     = '0;
    su_need_div = 1'b0;
    su_neg      = 1'b0;
    su_end      = 1'b0;
    su_dvd      = FullScale;
    su_dvs      = attack_n;
    if (seg_sel == SEG_ATTACK && attack_n != '0) begin
      su_phase    = PH_ATTACK;
      su_left     = attack_n;
      su_need_div = 1'b1;
    end else if (seg_sel <= SEG_DECAY && decay_n != '0) begin
      su_phase    = PH_DECAY;
      su_left     = decay_n;
      su_vol      = FullScale;
      su_need_div = 1'b1;
      su_neg      = 1'b1;
      su_dvd      = FullScale - {1'b0, sustain_r, FracW'(0)};
      su_dvs      = decay_n;
    end else if (seg_sel <= SEG_SUSTAIN && sustain_r != '0) begin
      su_phase    = PH_HOLD;
      su_left     = left_r;
      su_vol      = {1'b0, sustain_r, FracW'(0)};
    end else begin
      su_end      = 1'b1;
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = su_dvd;
    div_dvs   = su_dvs;
    if (accept) begin
      if (is_release) begin
        div_dvd   = volume_r;
        div_dvs   = rel_n;
        div_start = !finished_r && (rel_n != '0);
      end else begin
        div_start = (in_req.req_type == REQ_KEY_ON) && su_need_div;
      end
    end else if (state_r == S_TICK) begin
      div_start = expire && su_need_div;
    end
  end

  lae_div #(.DvsW(CntW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_comb begin
    slope_mag = delta_r[VolW-1] ? (VolW'(0) - delta_r) : delta_r;
    slope_cur = delta_r[VolW-1] ? (SlopeW'(0) - slope_mag[VolW-1:SlopeShift])
                                : slope_mag[VolW-1:SlopeShift];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_RELEASE;
      volume_r    <= '0;
      delta_r     <= '0;
      left_r      <= '0;
      finished_r  <= 1'b1;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_res.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            res_slope_r <= '0;
            resume_r    <= 1'b0;
            rem_r       <= (in_req.req_type == REQ_COARSE) ? RemW'(COARSE_TICKS) : RemW'(1);
            priority if (in_req.req_type == REQ_TICK || in_req.req_type == REQ_COARSE) begin
              res_done_r <= 1'b0;
              state_r    <= S_TICK;
            end else if (in_req.req_type == REQ_KEY_ON) begin
              phase_r     <= su_phase;
              volume_r    <= su_vol;
              left_r      <= su_left;
              finished_r  <= su_end;
              neg_r       <= su_neg;
              res_done_r  <= su_end;
              res_level_r <= su_vol[FracW +: LevelW];
              if (!su_need_div) begin
                delta_r <= '0;
              end
              state_r <= su_need_div ? S_DIV : S_FIN;
            end else if (is_release) begin
              if (!finished_r && rel_n == '0) begin
                phase_r     <= PH_RELEASE;
                volume_r    <= '0;
                delta_r     <= '0;
                left_r      <= '0;
                finished_r  <= 1'b1;
                res_done_r  <= 1'b1;
                res_level_r <= '0;
                state_r     <= S_FIN;
              end else if (!finished_r) begin
                phase_r     <= PH_RELEASE;
                left_r      <= rel_n;
                neg_r       <= 1'b1;
                res_done_r  <= 1'b0;
                res_level_r <= volume_r[FracW +: LevelW];
                state_r     <= S_DIV;
              end else begin
                res_done_r  <= 1'b0;
                res_level_r <= volume_r[FracW +: LevelW];
                state_r     <= S_FIN;
              end
            end else begin
              res_done_r  <= 1'b0;
              res_level_r <= volume_r[FracW +: LevelW];
              state_r     <= S_FIN;
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            delta_r <= neg_r ? (VolW'(0) - div_q) : div_q;
            state_r <= resume_r ? S_TICK : S_FIN;
          end
        end
        S_TICK: begin
          if (finished_r) begin
            res_level_r <= '0;
            res_slope_r <= '0;
            state_r     <= S_FIN;
          end else if (phase_r == PH_HOLD) begin
            res_level_r <= volume_r[FracW +: LevelW];
            res_slope_r <= '0;
            state_r     <= S_FIN;
          end else begin
            res_level_r <= volume_r[FracW +: LevelW];
            res_slope_r <= slope_cur;
            rem_r       <= rem_dec;
            if (expire) begin
              phase_r    <= su_phase;
              volume_r   <= su_vol;
              left_r     <= su_end ? CntW'(0) : su_left;
              finished_r <= su_end;
              neg_r      <= su_neg;
              resume_r   <= (rem_dec != '0);
              res_done_r <= su_end;
              if (!su_need_div) begin
                delta_r <= '0;
              end
              if (su_end) begin
                state_r <= S_FIN;
              end else if (su_need_div) begin
                state_r <= S_DIV;
              end else begin
                state_r <= (rem_dec == '0) ? S_FIN : S_TICK;
              end
            end else begin
              volume_r <= volume_r + delta_r;
              left_r   <= left_r - CntW'(1);
              state_r  <= (rem_dec == '0) ? S_FIN : S_TICK;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_res.ready) begin
            out_valid_r <= 1'b1;
            out_level_r <= res_level_r;
            out_slope_r <= res_slope_r;
            out_done_r  <= res_done_r;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_req.ready     = (state_r == S_IDLE);
  assign out_res.valid    = out_valid_r;
  assign out_res.level    = out_level_r;
  assign out_res.slope    = out_slope_r;
  assign out_res.done_res = out_done_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("divider finished while the sequencer was not waiting for it");

  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waits on an idle divider");

  a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> (volume_r == '0))
    else $error("finished envelope holds a nonzero level");

  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK) |-> (rem_r != '0 && rem_r <= RemW'(COARSE_TICKS)))
    else $error("tick loop count out of range");

endmodule
